>>> rtl/core/heat_cool_pid_regulator_macros.svh
// ----------------------------------------------------------------------------
// heat_cool_pid_regulator assertion macros
// shared concurrent assertion forms for the regulator core
// ----------------------------------------------------------------------------
`ifndef HEAT_COOL_PID_REGULATOR_MACROS_SVH
`define HEAT_COOL_PID_REGULATOR_MACROS_SVH

// property that holds at every edge outside reset
`define HCPID_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define HCPID_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define HCPID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/hcpid_pkg.sv
// ----------------------------------------------------------------------------
// hcpid_pkg
// widths, constants, control word and step map of the pid regulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcpid_pkg;

  localparam int GAIN_FRAC_BITS = 12;

  localparam int TEMP_W    = 13;
  localparam int ERR_W     = TEMP_W + 1;
  localparam int DT_W      = 10;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 30;
  localparam int INTEG_W   = 32;
  localparam int DIV_W     = 24;
  localparam int DERIV_W   = DIV_W + 1;
  localparam int MUL_A_W   = 32;
  localparam int PROD_W    = MUL_A_W + GAIN_W + 1;
  localparam int ACC_W     = PROD_W + 1;
  localparam int DUTY_W    = 8;
  localparam int STEP_W    = 4;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = LIM_W;

  localparam int DERIV_SCALE = 1000;
  localparam int DUTY_MAX    = 255;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1000000000);

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 2'd3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_ENTRY    = 4'd0;
  localparam step_t ST_MUL_DT   = 4'd1;
  localparam step_t ST_INT_ADD  = 4'd2;
  localparam step_t ST_CLAMP    = 4'd3;
  localparam step_t ST_DIV_INIT = 4'd4;
  localparam step_t ST_DIV      = 4'd5;
  localparam step_t ST_DIV_FIX  = 4'd6;
  localparam step_t ST_SUM_I    = 4'd7;
  localparam step_t ST_SUM_D    = 4'd8;
  localparam step_t ST_COMMIT   = 4'd9;
  localparam step_t ST_OFF      = 4'd10;
  localparam step_t ST_DONE     = 4'd11;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ERR,
    DP_INT_ADD,
    DP_INT_CLAMP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_FIX,
    DP_COMMIT,
    DP_OFF
  } dp_op_t;

  typedef enum logic [1:0] {
    MA_ERR,
    MA_DIFF,
    MA_INTEG,
    MA_DERIV
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_DT,
    MB_SCALE,
    MB_PROP,
    MB_INTEG,
    MB_DERIV
  } mul_b_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_JUMP,
    SQ_BR_OFF,
    SQ_BR_SKIP,
    SQ_LOOP,
    SQ_DONE
  } seq_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_en;
    mul_a_t mul_a;
    mul_b_t mul_b;
    logic   acc_clr;
    logic   acc_add;
    seq_t   seq;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    logic action_off;
    logic dt_zero;
    logic div_last;
  } status_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  integral_limit;
  } gains_t;

  localparam ucode_t UC_NOP = '{
    op: DP_NOP, mul_en: 1'b0, mul_a: MA_ERR, mul_b: MB_DT,
    acc_clr: 1'b0, acc_add: 1'b0, seq: SQ_DONE, target: ST_DONE
  };

endpackage

>>> rtl/core/heat_cool_pid_regulator.sv
// ----------------------------------------------------------------------------
// heat_cool_pid_regulator
// One control tick per input transaction; one result transaction per tick.
// A regulate tick with nonzero dt_ms runs 10 sequencer steps plus a 24-step
// restoring divider loop for the derivative term before the result is
// registered. Off ticks run ENTRY, OFF and DONE; zero-dt ticks run ENTRY,
// MUL_DT and DONE. in_stall stays high while the microcode sequencer runs,
// so the next tick is accepted at the earliest in the cycle after the result
// is registered; a waiting result does not block acceptance of the next tick,
// but the next result waits in its final step until the output register is
// free. Gains and the integral limit must be written through cfg_write/
// cfg_index/cfg_data while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heat_cool_pid_regulator_macros.svh"

module heat_cool_pid_regulator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [hcpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hcpid_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    action,
  input  logic signed [hcpid_pkg::TEMP_W-1:0]     measured_temp,
  input  logic signed [hcpid_pkg::TEMP_W-1:0]     target_temp,
  input  logic [hcpid_pkg::DT_W-1:0]              dt_ms,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [hcpid_pkg::DUTY_W-1:0]            heater_duty,
  output logic                                    heater_active,
  output logic                                    fan_active
);
  import hcpid_pkg::*;

  gains_t            gains;
  logic              busy;
  logic              busy_next;
  step_t             step;
  step_t             step_next;
  ucode_t            uc;
  ucode_t            ctrl;
  status_t           status;
  logic              out_load;
  logic              accept;
  logic [DUTY_W-1:0] last_duty;
  logic              last_fan;
  logic [DUTY_W-1:0] out_duty;
  logic              out_fan;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop_gain      <= '0;
      gains.integ_gain     <= '0;
      gains.deriv_gain     <= '0;
      gains.integral_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PROP_GAIN:  gains.prop_gain      <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN: gains.integ_gain     <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN: gains.deriv_gain     <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_LIM:  gains.integral_limit <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hcpid_ucode_rom u_rom (
    .step (step),
    .word (uc)
  );

  assign ctrl     = busy ? uc : UC_NOP;
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_ENTRY;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  always_comb begin
    busy_next = busy;
    step_next = step;
    out_load  = 1'b0;
    if (!busy) begin
      if (in_valid) begin
        busy_next = 1'b1;
        step_next = ST_ENTRY;
      end
    end else begin
      case (uc.seq)
        SQ_NEXT:    step_next = step + STEP_W'(1);
        SQ_JUMP:    step_next = uc.target;
        SQ_BR_OFF:  step_next = status.action_off ? uc.target : step + STEP_W'(1);
        SQ_BR_SKIP: step_next = status.dt_zero ? uc.target : step + STEP_W'(1);
        SQ_LOOP:    step_next = status.div_last ? step + STEP_W'(1) : uc.target;
        SQ_DONE: begin
          if (!out_valid || !out_stall) begin
            out_load  = 1'b1;
            busy_next = 1'b0;
          end
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  hcpid_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .action        (action),
    .measured_temp (measured_temp),
    .target_temp   (target_temp),
    .dt_ms         (dt_ms),
    .gains         (gains),
    .ctrl          (ctrl),
    .status        (status),
    .last_duty     (last_duty),
    .last_fan      (last_fan)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_duty <= last_duty;
      out_fan  <= last_fan;
    end
  end

  assign heater_duty   = out_duty;
  assign heater_active = out_duty != '0;
  assign fan_active    = out_fan;

  `HCPID_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall, "tick accepted but sequencer not started")
  `HCPID_ASSERT_IMPL(a_step_range, clk, rst, busy, step <= ST_DONE, "sequencer step outside program")
  `HCPID_ASSERT_IMPL(a_heat_xor_fan, clk, rst, out_valid && heater_active, !fan_active, "heater and fan both on")
  `HCPID_ASSERT(a_load_when_free, clk, rst, !out_load || !out_valid || !out_stall, "result overwrote a stalled transaction")

endmodule

>>> rtl/core/hcpid_ucode_rom.sv
// ----------------------------------------------------------------------------
// hcpid_ucode_rom
// control store: one control word per sequencer step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcpid_ucode_rom (
  input  hcpid_pkg::step_t  step,
  output hcpid_pkg::ucode_t word
);
  import hcpid_pkg::*;

  always_comb begin
    word = UC_NOP;
    case (step)
      ST_ENTRY: begin
        word.op     = DP_ERR;
        word.seq    = SQ_BR_OFF;
        word.target = ST_OFF;
      end
      ST_MUL_DT: begin
        word.mul_en = 1'b1;
        word.mul_a  = MA_ERR;
        word.mul_b  = MB_DT;
        word.seq    = SQ_BR_SKIP;
        word.target = ST_DONE;
      end
      ST_INT_ADD: begin
        word.op     = DP_INT_ADD;
        word.mul_en = 1'b1;
        word.mul_a  = MA_DIFF;
        word.mul_b  = MB_SCALE;
        word.seq    = SQ_NEXT;
      end
      ST_CLAMP: begin
        word.op  = DP_INT_CLAMP;
        word.seq = SQ_NEXT;
      end
      ST_DIV_INIT: begin
        word.op      = DP_DIV_INIT;
        word.mul_en  = 1'b1;
        word.mul_a   = MA_ERR;
        word.mul_b   = MB_PROP;
        word.acc_clr = 1'b1;
        word.seq     = SQ_NEXT;
      end
      ST_DIV: begin
        word.op     = DP_DIV_STEP;
        word.seq    = SQ_LOOP;
        word.target = ST_DIV;
      end
      ST_DIV_FIX: begin
        word.op      = DP_DIV_FIX;
        word.acc_add = 1'b1;
        word.mul_en  = 1'b1;
        word.mul_a   = MA_INTEG;
        word.mul_b   = MB_INTEG;
        word.seq     = SQ_NEXT;
      end
      ST_SUM_I: begin
        word.acc_add = 1'b1;
        word.mul_en  = 1'b1;
        word.mul_a   = MA_DERIV;
        word.mul_b   = MB_DERIV;
        word.seq     = SQ_NEXT;
      end
      ST_SUM_D: begin
        word.acc_add = 1'b1;
        word.seq     = SQ_NEXT;
      end
      ST_COMMIT: begin
        word.op     = DP_COMMIT;
        word.seq    = SQ_JUMP;
        word.target = ST_DONE;
      end
      ST_OFF: begin
        word.op  = DP_OFF;
        word.seq = SQ_NEXT;
      end
      ST_DONE: begin
        word.seq = SQ_DONE;
      end
      default: begin
        word = UC_NOP;
      end
    endcase
  end

endmodule

>>> rtl/core/hcpid_div.sv
// ----------------------------------------------------------------------------
// hcpid_div
// restoring divider, one quotient bit per step, unsigned operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcpid_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        step,
  input  logic [hcpid_pkg::DIV_W-1:0] dividend,
  input  logic [hcpid_pkg::DT_W-1:0]  divisor,
  output logic [hcpid_pkg::DIV_W-1:0] quotient,
  output logic                        last
);
  import hcpid_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [DT_W-1:0]  rem;
  logic [DIV_W-1:0] quo;
  logic [DT_W:0]    shifted;
  logic [DT_W:0]    sub;
  logic             ge;

  assign shifted  = {rem, quo[DIV_W-1]};
  assign ge       = shifted >= (DT_W+1)'(divisor);
  assign sub      = shifted - (DT_W+1)'(divisor);
  assign quotient = quo;
  assign last     = cnt == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(DIV_W);
    end else if (step) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= ge ? sub[DT_W-1:0] : shifted[DT_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/hcpid_datapath.sv
// ----------------------------------------------------------------------------
// hcpid_datapath
// operand registers, shared multiplier, accumulator and pid state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcpid_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                action,
  input  logic signed [hcpid_pkg::TEMP_W-1:0] measured_temp,
  input  logic signed [hcpid_pkg::TEMP_W-1:0] target_temp,
  input  logic [hcpid_pkg::DT_W-1:0]          dt_ms,
  input  hcpid_pkg::gains_t                   gains,
  input  hcpid_pkg::ucode_t                   ctrl,
  output hcpid_pkg::status_t                  status,
  output logic [hcpid_pkg::DUTY_W-1:0]        last_duty,
  output logic                                last_fan
);
  import hcpid_pkg::*;

  localparam int SH_W = ACC_W - GAIN_FRAC_BITS;

  logic                       action_r;
  logic signed [TEMP_W-1:0]   meas_r;
  logic signed [TEMP_W-1:0]   targ_r;
  logic [DT_W-1:0]            dt_r;

  logic signed [ERR_W-1:0]    err;
  logic signed [INTEG_W-1:0]  integ;
  logic signed [DERIV_W-1:0]  deriv;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       d_sign;

  logic signed [INTEG_W-1:0]  integral_sum;
  logic signed [ERR_W-1:0]    prev_err;

  logic signed [ERR_W:0]      diff;
  logic signed [MUL_A_W-1:0]  a_op;
  logic [GAIN_W-1:0]          b_op;
  logic signed [GAIN_W:0]     b_s;
  logic signed [PROD_W-1:0]   prod_next;
  logic [PROD_W-1:0]          prod_abs;
  logic signed [INTEG_W-1:0]  lim_s;
  logic [DIV_W-1:0]           quot;
  logic signed [DERIV_W-1:0]  q_s;
  logic                       div_last;
  logic [SH_W-1:0]            acc_sh;
  logic [DUTY_W-1:0]          duty_calc;
  logic                       err_pos;
  logic                       acc_pos;

  assign diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err);

  always_comb begin
    case (ctrl.mul_a)
      MA_ERR:   a_op = MUL_A_W'(err);
      MA_DIFF:  a_op = MUL_A_W'(diff);
      MA_INTEG: a_op = MUL_A_W'(integ);
      MA_DERIV: a_op = MUL_A_W'(deriv);
      default:  a_op = '0;
    endcase
    case (ctrl.mul_b)
      MB_DT:    b_op = GAIN_W'(dt_r);
      MB_SCALE: b_op = GAIN_W'(DERIV_SCALE);
      MB_PROP:  b_op = gains.prop_gain;
      MB_INTEG: b_op = gains.integ_gain;
      MB_DERIV: b_op = gains.deriv_gain;
      default:  b_op = '0;
    endcase
  end

  assign b_s       = {1'b0, b_op};
  assign prod_next = PROD_W'(a_op) * PROD_W'(b_s);
  assign prod_abs  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign lim_s     = $signed(INTEG_W'(gains.integral_limit));
  assign q_s       = $signed({1'b0, quot});

  assign err_pos   = !err[ERR_W-1] && (err != '0);
  assign acc_pos   = !acc[ACC_W-1] && (acc != '0);
  assign acc_sh    = acc[ACC_W-1:GAIN_FRAC_BITS];
  assign duty_calc = !acc_pos ? '0 :
                     (acc_sh > SH_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : acc_sh[DUTY_W-1:0];

  hcpid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (ctrl.op == DP_DIV_INIT),
    .step     (ctrl.op == DP_DIV_STEP),
    .dividend (prod_abs[DIV_W-1:0]),
    .divisor  (dt_r),
    .quotient (quot),
    .last     (div_last)
  );

  assign status.action_off = !action_r;
  assign status.dt_zero    = dt_r == '0;
  assign status.div_last   = div_last;

  // operand and working registers
  always_ff @(posedge clk) begin
    if (load) begin
      action_r <= action;
      meas_r   <= measured_temp;
      targ_r   <= target_temp;
      dt_r     <= dt_ms;
    end
    if (ctrl.mul_en) begin
      prod <= prod_next;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    case (ctrl.op)
      DP_ERR: begin
        err <= ERR_W'(targ_r) - ERR_W'(meas_r);
      end
      DP_INT_ADD: begin
        integ <= integral_sum + INTEG_W'(prod);
      end
      DP_INT_CLAMP: begin
        if (integ > lim_s) begin
          integ <= lim_s;
        end else if (integ < -lim_s) begin
          integ <= -lim_s;
        end
      end
      DP_DIV_INIT: begin
        d_sign <= prod[PROD_W-1];
      end
      DP_DIV_FIX: begin
        deriv <= d_sign ? -q_s : q_s;
      end
      default: begin
      end
    endcase
  end

  // pid state and last outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      prev_err     <= '0;
      last_duty    <= '0;
      last_fan     <= 1'b0;
    end else begin
      case (ctrl.op)
        DP_COMMIT: begin
          integral_sum <= integ;
          prev_err     <= err;
          last_duty    <= err_pos ? duty_calc : '0;
          last_fan     <= !err_pos;
        end
        DP_OFF: begin
          integral_sum <= '0;
          prev_err     <= '0;
          last_duty    <= '0;
          last_fan     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
